// ----- rtl/core/letterbox_layout_calc_defines.svh -----
// Assertion macros shared by the letterbox layout RTL.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef LETTERBOX_LAYOUT_CALC_DEFINES_SVH
`define LETTERBOX_LAYOUT_CALC_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define LBX_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define LBX_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LBX_CHECK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lbx_pkg.sv -----
// Shared types, constants and helpers of the letterbox layout calculator.
// No dependencies; used by lbx_div_pipe and letterbox_layout_calc.
`default_nettype none

package lbx_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = 13;
    localparam int COORD_W     = 15;
    localparam int PLACE_W     = 16;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int DIV_STAGES  = DIM_W + 1;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 112;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_ASPECT    = 1'd1;

    typedef logic [DIM_W-1:0]          dim_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [PROD_W-1:0]         prod_t;

    typedef enum logic [1:0] {
        MODE_FIT,
        MODE_PAD,
        MODE_ASPECT
    } mode_t;

    // Request data that rides alongside the divider.
    typedef struct packed {
        coord_t bound_left;
        coord_t bound_top;
        dim_t   bound_w;
        dim_t   bound_h;
        dim_t   src_w;
        dim_t   src_h;
        mode_t  mode;
        logic   letterbox;
    } side_t;

    // One divider stage word: partial remainder, divisor, quotient so far.
    typedef struct packed {
        prod_t rem;
        dim_t  den;
        dim_t  quo;
        side_t side;
    } div_word_t;

    // Saturate a size field into 1..MAX_DIM.
    function automatic dim_t clamp_dim(input dim_t v);
        dim_t r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/letterbox_layout_calc.sv -----
// Top level of the letterbox / pillarbox layout calculator.
// Depends on lbx_pkg, lbx_div_pipe and letterbox_layout_calc_defines.svh.
//
//  channel  | dir | payload (lowest bit first)                                  | accept
//  ---------+-----+-------------------------------------------------------------+-------------------
//  s_axis   | in  | bound_left, bound_top, bound_w, bound_h, src_w, src_h      | tvalid & tready
//  m_axis   | out | place_left, place_top, place_w, place_h, pads L/R/T/B      | tvalid & tready
//  cfg      | in  | cfg_addr (0 stretch_enable, 1 keep_aspect), cfg_wdata[0]   | cfg_we
//
// One word enters per cycle while m_axis is not stalled. The pipeline is one stage for the two size
// products, one operand load and 13 quotient-bit stages of the divider, and one output
// stage. Every stage holds its own valid bit and stalls only when the stage after it is
// full and stalled, so bubbles close up.
// Reset clears the valid bits and loads stretch_enable = 0, keep_aspect = 1.
`default_nettype none
`include "letterbox_layout_calc_defines.svh"

module letterbox_layout_calc
    import lbx_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // bound_left[14:0], bound_top[29:15], bound_w[42:30], bound_h[55:43],
    // src_w[68:56], src_h[81:69], zero fill [87:82]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // place_left[15:0], place_top[31:16], place_w[44:32], place_h[57:45],
    // pad_left[70:58], pad_right[83:71], pad_top[96:84], pad_bottom[109:97],
    // zero fill [111:110]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic                   cfg_wdata
);

    localparam int OUT_FILL_W = OUT_TDATA_W - (2 * PLACE_W + 6 * DIM_W);
    localparam int EXT_W      = PLACE_W - COORD_W;
    localparam int ZEXT_W     = PLACE_W - DIM_W;

    // ---------------- configuration registers ----------------
    logic stretch_enable_reg;
    logic keep_aspect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stretch_enable_reg <= 1'b0;
            keep_aspect_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_STRETCH_ENABLE: stretch_enable_reg <= cfg_wdata;
                REG_KEEP_ASPECT:    keep_aspect_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: clamp, mode, size products ----------------
    side_t in_side;
    dim_t  in_bw;
    dim_t  in_bh;
    dim_t  in_sw;
    dim_t  in_sh;
    logic  in_same;
    logic  in_fits;

    assign in_bw   = clamp_dim(s_axis_tdata[42:30]);
    assign in_bh   = clamp_dim(s_axis_tdata[55:43]);
    assign in_sw   = clamp_dim(s_axis_tdata[68:56]);
    assign in_sh   = clamp_dim(s_axis_tdata[81:69]);
    assign in_same = (in_sw == in_bw) && (in_sh == in_bh);
    assign in_fits = (in_sw <= in_bw) && (in_sh <= in_bh);

    always_comb
    begin
        in_side.bound_left = s_axis_tdata[14:0];
        in_side.bound_top  = s_axis_tdata[29:15];
        in_side.bound_w    = in_bw;
        in_side.bound_h    = in_bh;
        in_side.src_w      = in_sw;
        in_side.src_h      = in_sh;
        in_side.letterbox  = 1'b0;
        // Equal sizes fill; a fitting source without stretch is centered as is.
        if (in_same)
        begin
            in_side.mode = MODE_FIT;
        end
        else if (in_fits && !stretch_enable_reg)
        begin
            in_side.mode = MODE_PAD;
        end
        else if (keep_aspect_reg)
        begin
            in_side.mode = MODE_ASPECT;
        end
        else
        begin
            in_side.mode = MODE_FIT;
        end
    end

    logic  s1_vld_reg;
    logic  s1_rdy;
    side_t s1_side_reg;
    prod_t s1_swbh_reg;   // src_w * bound_h
    prod_t s1_bwsh_reg;   // bound_w * src_h
    prod_t s1_swbh_next;
    prod_t s1_bwsh_next;
    logic  div_in_ready;

    assign s1_swbh_next  = prod_t'(in_sw) * prod_t'(in_bh);
    assign s1_bwsh_next  = prod_t'(in_bw) * prod_t'(in_sh);
    assign s1_rdy        = !s1_vld_reg || div_in_ready;
    assign s_axis_tready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (s1_rdy)
        begin
            s1_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            s1_side_reg <= in_side;
            s1_swbh_reg <= s1_swbh_next;
            s1_bwsh_reg <= s1_bwsh_next;
        end
    end

    // ---------------- divider operands ----------------
    // Letterbox when src_w*bound_h >= bound_w*src_h: the scaled height is
    // ceil(bound_w*src_h / src_w). Otherwise the scaled width is
    // ceil(bound_h*src_w / src_h). Ceiling comes from adding divisor - 1.
    div_word_t div_in;
    div_word_t div_out;
    logic      div_out_valid;
    logic      div_out_ready;
    logic      lb_sel;
    prod_t     num_lb;
    prod_t     num_pb;

    assign lb_sel = s1_swbh_reg >= s1_bwsh_reg;
    assign num_lb = s1_bwsh_reg + prod_t'(s1_side_reg.src_w) - prod_t'(1);
    assign num_pb = s1_swbh_reg + prod_t'(s1_side_reg.src_h) - prod_t'(1);

    always_comb
    begin
        div_in           = '0;
        div_in.side      = s1_side_reg;
        div_in.side.letterbox = lb_sel;
        div_in.rem       = lb_sel ? num_lb : num_pb;
        div_in.den       = lb_sel ? s1_side_reg.src_w : s1_side_reg.src_h;
    end

    lbx_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_vld_reg),
        .in_ready  (div_in_ready),
        .in_word   (div_in),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_word  (div_out)
    );

    // ---------------- output stage: sizes, offsets, margins ----------------
    // Centering offset is floor(slack / 2) for every mode; the far margin takes
    // the rest of the slack.
    dim_t pw;
    dim_t ph;
    dim_t slack_w;
    dim_t slack_h;
    dim_t ox;
    dim_t oy;
    dim_t pad_r;
    dim_t pad_b;
    logic [PLACE_W-1:0] place_l;
    logic [PLACE_W-1:0] place_t;

    always_comb
    begin
        case (div_out.side.mode)
            MODE_PAD:
            begin
                pw = div_out.side.src_w;
                ph = div_out.side.src_h;
            end
            MODE_ASPECT:
            begin
                pw = div_out.side.letterbox ? div_out.side.bound_w : div_out.quo;
                ph = div_out.side.letterbox ? div_out.quo : div_out.side.bound_h;
            end
            default:
            begin
                pw = div_out.side.bound_w;
                ph = div_out.side.bound_h;
            end
        endcase
    end

    assign slack_w = div_out.side.bound_w - pw;
    assign slack_h = div_out.side.bound_h - ph;
    assign ox      = slack_w >> 1;
    assign oy      = slack_h >> 1;
    assign pad_r   = slack_w - ox;
    assign pad_b   = slack_h - oy;
    assign place_l = {{EXT_W{div_out.side.bound_left[COORD_W-1]}}, div_out.side.bound_left}
                     + {{ZEXT_W{1'b0}}, ox};
    assign place_t = {{EXT_W{div_out.side.bound_top[COORD_W-1]}}, div_out.side.bound_top}
                     + {{ZEXT_W{1'b0}}, oy};

    logic                   out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    assign div_out_ready = !out_vld_reg || m_axis_tready;
    assign out_data_next = {{OUT_FILL_W{1'b0}}, pad_b, oy, pad_r, ox, ph, pw,
                            place_t, place_l};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (div_out_ready)
        begin
            out_vld_reg <= div_out_valid;
        end
    end

    // Hold the word while the sink stalls.
    always_ff @(posedge clk)
    begin
        if (div_out_ready)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- checks ----------------
    `LBX_CHECK_IMP(a_size_nonzero, out_vld_reg,
        (out_data_reg[44:32] != '0) && (out_data_reg[57:45] != '0),
        "placed size is zero")
    `LBX_CHECK_IMP(a_pad_lr_split, out_vld_reg,
        (out_data_reg[70:58] <= out_data_reg[83:71]) &&
        ({1'b0, out_data_reg[83:71]} <= ({1'b0, out_data_reg[70:58]} + 14'd1)),
        "left/right margins not a floor/ceil split")
    `LBX_CHECK_IMP(a_pad_tb_split, out_vld_reg,
        (out_data_reg[96:84] <= out_data_reg[109:97]) &&
        ({1'b0, out_data_reg[109:97]} <= ({1'b0, out_data_reg[96:84]} + 14'd1)),
        "top/bottom margins not a floor/ceil split")
    `LBX_CHECK_NXT(a_s1_hold, s1_vld_reg && !s1_rdy,
        s1_vld_reg && $stable(s1_side_reg), "stage 1 word lost under stall")

endmodule

`default_nettype wire

// ----- rtl/core/lbx_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with per-stage stall.
// Depends on lbx_pkg and letterbox_layout_calc_defines.svh.
`default_nettype none
`include "letterbox_layout_calc_defines.svh"

module lbx_div_pipe
    import lbx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire div_word_t in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output div_word_t      out_word
);

    // Stage 0 loads the operands; stage k retires quotient bit DIM_W-k.
    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] vld_next;
    logic [DIV_STAGES-1:0] rdy;
    div_word_t             word_reg  [DIV_STAGES];
    div_word_t             word_next [DIV_STAGES];

    always_comb
    begin
        rdy[DIV_STAGES-1] = !vld_reg[DIV_STAGES-1] || out_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        vld_next[0]  = in_valid;
        word_next[0] = in_word;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            vld_next[k]  = vld_reg[k-1];
            word_next[k] = word_reg[k-1];
            if (word_reg[k-1].rem >= (prod_t'(word_reg[k-1].den) << (DIM_W - k)))
            begin
                word_next[k].rem = word_reg[k-1].rem
                                   - (prod_t'(word_reg[k-1].den) << (DIM_W - k));
                word_next[k].quo = {word_reg[k-1].quo[DIM_W-2:0], 1'b1};
            end
            else
            begin
                word_next[k].quo = {word_reg[k-1].quo[DIM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (rdy[k])
            begin
                word_reg[k] <= word_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_word  = word_reg[DIV_STAGES-1];

    `LBX_CHECK_IMP(a_rem_below_den, out_valid,
        out_word.rem < prod_t'(out_word.den), "divider remainder not below divisor")
    `LBX_CHECK_IMP(a_quo_range, out_valid,
        (out_word.quo != '0) && (out_word.quo <= DIM_W'(MAX_DIM)),
        "divider quotient outside 1..MAX_DIM")

endmodule

`default_nettype wire
